>>> rtl/core/arem_pkg.sv
// Shared types and constants for the access rights matrix engine.
package arem_pkg;

	localparam int DEF_MAX_SUBJECTS = 16;
	localparam int DEF_MAX_OBJECTS  = 16;

	// Position and count width for the cell array control; covers sizes up to 254 plus one.
	localparam int POS_W     = 8;
	localparam int RIGHTS_W  = 4;
	localparam int INDEX_W   = 4;
	localparam int CNT_OUT_W = 5;

	localparam logic [RIGHTS_W-1:0] RIGHT_READ = 4'b0001;

	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [RIGHTS_W-1:0] rights_t;

	typedef enum logic [2:0] {
		ACT_LOAD       = 3'd0,
		ACT_CREATE_OBJ = 3'd1,
		ACT_CREATE_SUB = 3'd2,
		ACT_DESTROY_OBJ = 3'd3,
		ACT_DESTROY_SUB = 3'd4,
		ACT_ENTER      = 3'd5,
		ACT_DELETE     = 3'd6,
		ACT_READ       = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_REJECT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		action_t              action;
		logic [INDEX_W-1:0]   subject_index;
		logic [INDEX_W-1:0]   object_index;
		rights_t              rights_mask;
	} cmd_item_t;

	typedef struct packed {
		status_t              status;
		rights_t              cell_rights;
		logic [CNT_OUT_W-1:0] subject_count;
		logic [CNT_OUT_W-1:0] object_count;
	} rsp_item_t;

	// Broadcast command to every cell; each op flag is already qualified and gated.
	typedef struct packed {
		logic    op_load;
		logic    op_ins_col;
		logic    op_ins_row;
		logic    op_del_col;
		logic    op_del_row;
		logic    op_enter;
		logic    op_clear;
		pos_t    row_idx;
		pos_t    col_idx;
		pos_t    row_cnt;
		pos_t    col_cnt;
		rights_t mask;
	} cell_ctl_t;

endpackage

>>> rtl/core/arem_cell.sv
// One rights cell of the matrix: its register and its next-state logic.
module arem_cell
	import arem_pkg::*;
#(
	parameter int ROW = 0,
	parameter int COL = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  rights_t   left,
	input  rights_t   up,
	input  rights_t   right,
	input  rights_t   down,
	output rights_t   cur,
	output rights_t   nxt
);

	localparam pos_t R = POS_W'(ROW);
	localparam pos_t C = POS_W'(COL);
	localparam pos_t R1 = POS_W'(ROW + 1);
	localparam pos_t C1 = POS_W'(COL + 1);

	rights_t cell_q;
	logic    hit;

	assign hit = (ctl.row_idx == R) && (ctl.col_idx == C);

	// Pick the new cell value from the command and the neighbors
	always_comb begin
		nxt = cell_q;
		if (ctl.op_load && hit) begin
			nxt = ctl.mask;
		end else if (ctl.op_enter && hit) begin
			nxt = cell_q | ctl.mask;
		end else if (ctl.op_clear && hit) begin
			nxt = cell_q & ~ctl.mask;
		end else if (ctl.op_ins_col && (R < ctl.row_cnt)) begin
			if (C == ctl.col_idx) begin
				nxt = RIGHT_READ;
			end else if ((C > ctl.col_idx) && (C <= ctl.col_cnt)) begin
				nxt = left;
			end
		end else if (ctl.op_ins_row && (C < ctl.col_cnt)) begin
			if (R == ctl.row_idx) begin
				nxt = RIGHT_READ;
			end else if ((R > ctl.row_idx) && (R <= ctl.row_cnt)) begin
				nxt = up;
			end
		end else if (ctl.op_del_col && (C >= ctl.col_idx) && (C < ctl.col_cnt)) begin
			nxt = (C1 < ctl.col_cnt) ? right : '0;
		end else if (ctl.op_del_row && (R >= ctl.row_idx) && (R < ctl.row_cnt)) begin
			nxt = (R1 < ctl.row_cnt) ? down : '0;
		end
	end

	// Hold the cell; unchanged when no op is active
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q <= nxt;
		end
	end

	assign cur = cell_q;

endmodule

>>> rtl/core/access_rights_matrix_engine.sv
// Access rights matrix engine: command decode, cell array and result register.
// Path: an accepted command beat passes through the input stage register into the response register.
// Throughput: one command per cycle while responses are not stalled; every cell updates in parallel from its neighbors.
// Row and column shifts finish in the same cycle as any other command.
// Reset: arst_n clears all cells, both counts and both valid flags at once.
module access_rights_matrix_engine
	import arem_pkg::*;
#(
	parameter int MAX_SUBJECTS = DEF_MAX_SUBJECTS,
	parameter int MAX_OBJECTS  = DEF_MAX_OBJECTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int SCW = $clog2(MAX_SUBJECTS + 1);
	localparam int OCW = $clog2(MAX_OBJECTS + 1);
	localparam int SIW = $clog2(MAX_SUBJECTS);
	localparam int OIW = $clog2(MAX_OBJECTS);
	localparam pos_t MAX_S = POS_W'(MAX_SUBJECTS);
	localparam pos_t MAX_O = POS_W'(MAX_OBJECTS);

	logic       valid_s1;
	cmd_item_t  cmd_s1;
	logic       adv;
	logic [SCW-1:0] ns_q;
	logic [OCW-1:0] no_q;
	rsp_item_t  rsp_q;
	logic       rsp_valid_q;

	pos_t       si, oi, ns, no, ns_d, no_d;
	pos_t       ins_col_idx, ins_row_idx;
	logic       nonempty, in_matrix, load_ok, dcol_ok, drow_ok;
	status_t    status_d;
	rights_t    cell_rd;
	cell_ctl_t  ctl;

	rights_t cell_cur [MAX_SUBJECTS][MAX_OBJECTS];
	rights_t cell_nxt [MAX_SUBJECTS][MAX_OBJECTS];

	// Advance the input stage when the response register is free
	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	// Widen indexes and counts to one compare width
	assign si = POS_W'(cmd_s1.subject_index);
	assign oi = POS_W'(cmd_s1.object_index);
	assign ns = POS_W'(ns_q);
	assign no = POS_W'(no_q);

	assign nonempty    = (ns != '0) && (no != '0);
	assign in_matrix   = (ns != '0) && (si < ns) && (oi < no);
	assign load_ok     = (si < MAX_S) && (oi < MAX_O);
	assign dcol_ok     = (ns != '0) && (oi < no);
	assign drow_ok     = (ns != '0) && (si < ns);
	assign ins_col_idx = (oi > no) ? no : oi;
	assign ins_row_idx = (si > ns) ? ns : si;

	// Decode the command into a status, new counts and cell control
	always_comb begin
		status_d    = ST_REJECT;
		ns_d        = ns;
		no_d        = no;
		ctl         = '0;
		ctl.row_idx = si;
		ctl.col_idx = oi;
		ctl.row_cnt = ns;
		ctl.col_cnt = no;
		ctl.mask    = cmd_s1.rights_mask;
		unique case (cmd_s1.action)
			ACT_LOAD: begin
				if (load_ok) begin
					status_d    = ST_DONE;
					ctl.op_load = adv;
					if (ns < si + 1'b1) ns_d = si + 1'b1;
					if (no < oi + 1'b1) no_d = oi + 1'b1;
				end
			end
			ACT_CREATE_OBJ: begin
				ctl.col_idx = ins_col_idx;
				if (!nonempty) begin
					status_d = ST_REJECT;
				end else if (no >= MAX_O) begin
					status_d = ST_FULL;
				end else begin
					status_d       = ST_DONE;
					ctl.op_ins_col = adv;
					no_d           = no + 1'b1;
				end
			end
			ACT_CREATE_SUB: begin
				ctl.row_idx = ins_row_idx;
				if (!nonempty) begin
					status_d = ST_REJECT;
				end else if (ns >= MAX_S) begin
					status_d = ST_FULL;
				end else begin
					status_d       = ST_DONE;
					ctl.op_ins_row = adv;
					ns_d           = ns + 1'b1;
				end
			end
			ACT_DESTROY_OBJ: begin
				if (dcol_ok) begin
					status_d       = ST_DONE;
					ctl.op_del_col = adv;
					no_d           = no - 1'b1;
				end
			end
			ACT_DESTROY_SUB: begin
				if (drow_ok) begin
					status_d       = ST_DONE;
					ctl.op_del_row = adv;
					ns_d           = ns - 1'b1;
					// an empty matrix has no row width
					if (ns == POS_W'(1)) no_d = '0;
				end
			end
			ACT_ENTER: begin
				if (in_matrix) begin
					status_d     = ST_DONE;
					ctl.op_enter = adv;
				end
			end
			ACT_DELETE: begin
				if (in_matrix) begin
					status_d     = ST_DONE;
					ctl.op_clear = adv;
				end
			end
			ACT_READ: begin
				if (in_matrix) status_d = ST_DONE;
			end
			default: begin
				status_d = ST_REJECT;
			end
		endcase
	end

	// Cell array; edge neighbors read as no rights
	for (genvar r = 0; r < MAX_SUBJECTS; r++) begin : g_row
		for (genvar c = 0; c < MAX_OBJECTS; c++) begin : g_col
			rights_t nb_left, nb_up, nb_right, nb_down;
			if (c > 0) begin : g_l
				assign nb_left = cell_cur[r][c-1];
			end else begin : g_l0
				assign nb_left = '0;
			end
			if (r > 0) begin : g_u
				assign nb_up = cell_cur[r-1][c];
			end else begin : g_u0
				assign nb_up = '0;
			end
			if (c < MAX_OBJECTS - 1) begin : g_r
				assign nb_right = cell_cur[r][c+1];
			end else begin : g_r0
				assign nb_right = '0;
			end
			if (r < MAX_SUBJECTS - 1) begin : g_d
				assign nb_down = cell_cur[r+1][c];
			end else begin : g_d0
				assign nb_down = '0;
			end
			arem_cell #(
				.ROW(r),
				.COL(c)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.left   (nb_left),
				.up     (nb_up),
				.right  (nb_right),
				.down   (nb_down),
				.cur    (cell_cur[r][c]),
				.nxt    (cell_nxt[r][c])
			);
		end
	end

	// Read the addressed cell as it stands after the command
	always_comb begin
		cell_rd = '0;
		if ((si < ns_d) && (oi < no_d)) begin
			cell_rd = cell_nxt[si[SIW-1:0]][oi[OIW-1:0]];
		end
	end

	// Update counts on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q <= '0;
			no_q <= '0;
		end else if (adv) begin
			ns_q <= SCW'(ns_d);
			no_q <= OCW'(no_d);
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.status        <= status_d;
			rsp_q.cell_rights   <= cell_rd;
			rsp_q.subject_count <= CNT_OUT_W'(ns_d);
			rsp_q.object_count  <= CNT_OUT_W'(no_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Counts stay within capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(POS_W'(ns_q) <= MAX_S) && (POS_W'(no_q) <= MAX_O))
		else $error("matrix count exceeds capacity");

	// No columns without rows
	a_empty_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(ns_q == '0) |-> (no_q == '0))
		else $error("columns in use with no rows");

	// A refused command leaves the counts alone
	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (status_d != ST_DONE)) |=> ($stable(ns_q) && $stable(no_q)))
		else $error("refused command changed the counts");

	// Reported counts match the state just written
	a_rsp_counts: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> ((rsp.subject_count == CNT_OUT_W'(ns_q))
			&& (rsp.object_count == CNT_OUT_W'(no_q))))
		else $error("response counts differ from state");

	// The far corner cell stays clear while the matrix is not full
	a_corner_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((POS_W'(ns_q) < MAX_S) || (POS_W'(no_q) < MAX_O))
			|-> (cell_cur[MAX_SUBJECTS-1][MAX_OBJECTS-1] == '0))
		else $error("cell outside the used region holds rights");

endmodule

>>> dv/access_rights_matrix_checker.sv
// Checker that predicts access matrix responses and compares them with the engine output.
`timescale 1ns / 1ps
module access_rights_matrix_checker
	import arem_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  cmd_item_t cmd,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_item_t rsp,
	output int        mismatch_count,
	output int        answers_owed
);

	localparam int ROWS = DEF_MAX_SUBJECTS;
	localparam int COLS = DEF_MAX_OBJECTS;

	// Shadow copy of the matrix and its in-use extent
	rights_t   grid [ROWS][COLS];
	int        rows_used;
	int        cols_used;
	rsp_item_t owed_answers [$];
	rsp_item_t want_rsp;

	initial begin
		mismatch_count = 0;
		answers_owed = 0;
	end

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Apply one command beat to the shadow matrix and build the answer it should give
	function automatic rsp_item_t apply_matrix_command(input cmd_item_t c);
		rsp_item_t r;
		status_t   st;
		int        si;
		int        oi;
		int        idx;
		bit        in_region;
		si = c.subject_index;
		oi = c.object_index;
		st = ST_REJECT;
		in_region = rows_used != 0 && si < rows_used && oi < cols_used;
		case (c.action)
			ACT_LOAD: begin
				if (si < ROWS && oi < COLS) begin
					grid[si][oi] = c.rights_mask;
					if (rows_used < si + 1) rows_used = si + 1;
					if (cols_used < oi + 1) cols_used = oi + 1;
					st = ST_DONE;
				end
			end
			ACT_CREATE_OBJ: begin
				// Emptiness is checked before capacity
				if (rows_used == 0 || cols_used == 0) st = ST_REJECT;
				else if (cols_used >= COLS) st = ST_FULL;
				else begin
					idx = (oi > cols_used) ? cols_used : oi;
					for (int s = 0; s < rows_used; s++) begin
						for (int o = cols_used; o > idx; o--) grid[s][o] = grid[s][o-1];
						grid[s][idx] = RIGHT_READ;
					end
					cols_used++;
					st = ST_DONE;
				end
			end
			ACT_CREATE_SUB: begin
				if (rows_used == 0 || cols_used == 0) st = ST_REJECT;
				else if (rows_used >= ROWS) st = ST_FULL;
				else begin
					idx = (si > rows_used) ? rows_used : si;
					for (int s = rows_used; s > idx; s--)
						for (int o = 0; o < cols_used; o++) grid[s][o] = grid[s-1][o];
					for (int o = 0; o < cols_used; o++) grid[idx][o] = RIGHT_READ;
					rows_used++;
					st = ST_DONE;
				end
			end
			ACT_DESTROY_OBJ: begin
				if (rows_used != 0 && oi < cols_used) begin
					for (int s = 0; s < rows_used; s++) begin
						for (int o = oi; o + 1 < cols_used; o++) grid[s][o] = grid[s][o+1];
						grid[s][cols_used-1] = '0;
					end
					cols_used--;
					st = ST_DONE;
				end
			end
			ACT_DESTROY_SUB: begin
				if (rows_used != 0 && si < rows_used) begin
					for (int s = si; s + 1 < rows_used; s++)
						for (int o = 0; o < cols_used; o++) grid[s][o] = grid[s+1][o];
					for (int o = 0; o < cols_used; o++) grid[rows_used-1][o] = '0;
					rows_used--;
					// An empty matrix has no row width
					if (rows_used == 0) cols_used = 0;
					st = ST_DONE;
				end
			end
			ACT_ENTER: begin
				if (in_region) begin
					grid[si][oi] = grid[si][oi] | c.rights_mask;
					st = ST_DONE;
				end
			end
			ACT_DELETE: begin
				if (in_region) begin
					grid[si][oi] = grid[si][oi] & ~c.rights_mask;
					st = ST_DONE;
				end
			end
			default: begin
				if (in_region) st = ST_DONE;
			end
		endcase
		r.status = st;
		r.cell_rights = (si < rows_used && oi < cols_used) ? grid[si][oi] : '0;
		r.subject_count = CNT_OUT_W'(rows_used);
		r.object_count = CNT_OUT_W'(cols_used);
		return r;
	endfunction

	// Predict on each command beat, compare on each response beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (grid[s, o]) grid[s][o] = '0;
			rows_used = 0;
			cols_used = 0;
			owed_answers.delete();
		end else begin
			if (cmd_valid && cmd_ready)
				owed_answers.insert(owed_answers.size(), apply_matrix_command(cmd));
			if (rsp_valid && rsp_ready) begin
				if (owed_answers.size() == 0) begin
					report_mismatch("response beat with nothing pending", rsp, -1);
				end else begin
					want_rsp = owed_answers.pop_front();
					if (rsp.status != want_rsp.status)
						report_mismatch("status", rsp.status, want_rsp.status);
					if (rsp.cell_rights != want_rsp.cell_rights)
						report_mismatch("cell_rights", rsp.cell_rights, want_rsp.cell_rights);
					if (rsp.subject_count != want_rsp.subject_count)
						report_mismatch("subject_count", rsp.subject_count,
							want_rsp.subject_count);
					if (rsp.object_count != want_rsp.object_count)
						report_mismatch("object_count", rsp.object_count,
							want_rsp.object_count);
				end
			end
		end
		answers_owed <= owed_answers.size();
	end

endmodule

>>> dv/tb_access_rights_matrix_engine.sv
// Testbench top: drives matrix commands under varied backpressure and gives the verdict.
`timescale 1ns / 1ps
module tb_access_rights_matrix_engine;
	import arem_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 460;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_item_t cmd;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;
	int        mismatch_count;
	int        answers_owed;
	int        sender_idle_pct;
	int        receiver_stall_pct;
	int        quiet_cycles;

	access_rights_matrix_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	access_rights_matrix_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.answers_owed   (answers_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the response channel at the current rate
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// End the run when no beat moves on either channel for too long
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Send one command beat, idling first at the current rate
	task automatic send_cmd(input action_t act, input int si, input int oi, input int mask);
		cmd_item_t c;
		c.action = act;
		c.subject_index = INDEX_W'(si);
		c.object_index = INDEX_W'(oi);
		c.rights_mask = RIGHTS_W'(mask);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// Favor low indices half the time so small matrices see hits too
	function automatic int pick_index();
		return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 7);
	endfunction

	task automatic issue_random_command();
		int      pick;
		action_t act;
		pick = $urandom_range(0, 99);
		if (pick < 15) act = ACT_LOAD;
		else if (pick < 25) act = ACT_CREATE_OBJ;
		else if (pick < 35) act = ACT_CREATE_SUB;
		else if (pick < 47) act = ACT_DESTROY_OBJ;
		else if (pick < 59) act = ACT_DESTROY_SUB;
		else if (pick < 73) act = ACT_ENTER;
		else if (pick < 87) act = ACT_DELETE;
		else act = ACT_READ;
		send_cmd(act, pick_index(), pick_index(), $urandom_range(0, 15));
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_ready = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty matrix: every command but load is rejected
		send_cmd(ACT_READ, 0, 0, 0);
		send_cmd(ACT_CREATE_OBJ, 0, 0, 0);
		send_cmd(ACT_CREATE_SUB, 0, 0, 0);
		send_cmd(ACT_DESTROY_OBJ, 0, 0, 0);
		send_cmd(ACT_DESTROY_SUB, 0, 0, 0);
		send_cmd(ACT_ENTER, 0, 0, 15);
		// Grow by load, append past the end, insert at the front, shift out
		send_cmd(ACT_LOAD, 1, 2, 5);
		send_cmd(ACT_CREATE_OBJ, 0, 15, 0);
		send_cmd(ACT_CREATE_SUB, 0, 0, 0);
		send_cmd(ACT_DESTROY_OBJ, 2, 1, 0);
		send_cmd(ACT_DESTROY_SUB, 2, 0, 0);
		send_cmd(ACT_DESTROY_SUB, 0, 0, 0);
		// Destroy the last row, which also drops the column count
		send_cmd(ACT_DESTROY_SUB, 0, 0, 0);
		// Fill to capacity, then hit the full limits
		send_cmd(ACT_LOAD, 0, 0, 15);
		send_cmd(ACT_LOAD, 15, 15, 0);
		send_cmd(ACT_CREATE_OBJ, 4, 4, 0);
		send_cmd(ACT_CREATE_SUB, 4, 4, 0);
		send_cmd(ACT_ENTER, 15, 15, 15);
		send_cmd(ACT_DELETE, 15, 15, 5);
		send_cmd(ACT_READ, 15, 15, 0);
		send_cmd(ACT_DESTROY_OBJ, 3, 15, 0);
		send_cmd(ACT_READ, 15, 15, 0);
		send_cmd(ACT_CREATE_OBJ, 0, 15, 0);
		send_cmd(ACT_DESTROY_SUB, 15, 3, 0);
		send_cmd(ACT_CREATE_SUB, 15, 0, 0);
		send_cmd(ACT_DELETE, 0, 0, 15);

		// Random commands across four backpressure phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
				default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				issue_random_command();
				// Now and then wipe every row to revisit the empty matrix
				if (n % 100 == 99 && $urandom_range(0, 3) == 0)
					repeat (17) send_cmd(ACT_DESTROY_SUB, 0, $urandom_range(0, 15),
						$urandom_range(0, 15));
			end
		end
		cmd_valid <= 1'b0;

		// Let the last accepted beat show up in the owed count, then drain
		@(posedge clk);
		while (answers_owed != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && answers_owed == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/arem_pkg.sv
rtl/core/arem_cell.sv
rtl/core/access_rights_matrix_engine.sv
dv/access_rights_matrix_checker.sv
dv/tb_access_rights_matrix_engine.sv
